FILE: hw/rtl/three_byte_frame_fifo_defines.svh
// Assertion macros shared by the frame FIFO RTL.
// Each macro checks a property sampled on clk while rst_n is high.
`ifndef THREE_BYTE_FRAME_FIFO_DEFINES_SVH
`define THREE_BYTE_FRAME_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TBFF_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("frame fifo assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TBFF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("frame fifo assertion failed");

`else

`define TBFF_ASSERT_SAME(lbl, pre, post)
`define TBFF_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: hw/rtl/tbff_pkg.sv
package tbff_pkg;

  // Frame store geometry.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int FILL_W  = 5;
  localparam int BYTE_W  = 8;

  // Operation queue between the front and back parts.
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = 1;
  localparam int OPQ_CNT_W = 2;

  // Byte assembler phase that completes a frame.
  localparam logic [1:0] PHASE_LAST = 2'd2;

  // Reply codes for receive items.
  localparam logic [BYTE_W-1:0] REPLY_PARTIAL = 8'hFF;
  localparam logic [BYTE_W-1:0] REPLY_NONE    = 8'h00;

  typedef enum logic [1:0] {
    OP_PARTIAL,
    OP_FRAME,
    OP_READ
  } op_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] high;
    logic [BYTE_W-1:0] low;
  } frame_t;

  typedef struct packed {
    op_kind_t kind;
    frame_t   frame;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] reply;
    logic              frame_valid;
    frame_t            frame;
    logic [FILL_W-1:0] fill_level;
  } result_t;

endpackage

FILE: hw/rtl/tbff_ram.sv
module tbff_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/tbff_front.sv
module tbff_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_func,
  input  logic [7:0]              in_rx_byte,
  output logic                    op_valid,
  output tbff_pkg::op_t           op,
  input  logic                    op_take
);

  import tbff_pkg::*;

  logic [1:0]             byte_phase_r, byte_phase_nxt;
  logic [BYTE_W-1:0]      held_r [2];
  logic                   accept;
  op_t                    new_op;

  op_t                    q_op_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0]   q_wr_r, q_rd_r;
  logic [OPQ_CNT_W-1:0]   q_cnt_r, q_cnt_nxt;

  assign full   = (q_cnt_r == OPQ_CNT_W'(OPQ_DEPTH));
  assign accept = push && !full;

  // Classify the item and advance the byte assembler.
  always_comb begin
    byte_phase_nxt   = byte_phase_r;
    new_op.kind      = OP_READ;
    new_op.frame     = '{command: held_r[0], high: held_r[1], low: in_rx_byte};
    if (!in_func) begin
      if (byte_phase_r < PHASE_LAST) begin
        new_op.kind    = OP_PARTIAL;
        byte_phase_nxt = byte_phase_r + 2'd1;
      end else begin
        new_op.kind    = OP_FRAME;
        byte_phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_phase_r <= '0;
    end else if (accept) begin
      byte_phase_r <= byte_phase_nxt;
    end
  end

  // Held command and high bytes need no reset; they are written before use.
  always_ff @(posedge clk) begin
    if (accept && !in_func && (byte_phase_r < PHASE_LAST)) begin
      held_r[byte_phase_r[0]] <= in_rx_byte;
    end
  end

  // Small operation queue toward the back part.
  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (accept && !op_take) begin
      q_cnt_nxt = q_cnt_r + OPQ_CNT_W'(1);
    end else if (!accept && op_take) begin
      q_cnt_nxt = q_cnt_r - OPQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (accept) begin
        q_wr_r <= q_wr_r + OPQ_PTR_W'(1);
      end
      if (op_take) begin
        q_rd_r <= q_rd_r + OPQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op_r[q_wr_r] <= new_op;
    end
  end

  assign op_valid = (q_cnt_r != '0);
  assign op       = q_op_r[q_rd_r];

endmodule

FILE: hw/rtl/tbff_back.sv
module tbff_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  tbff_pkg::op_t     op,
  output logic              op_take,
  output logic              empty,
  input  logic              pop,
  output tbff_pkg::result_t res
);

  import tbff_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;

  logic               ram_we;
  frame_t             ram_rdata;
  logic [$bits(frame_t)-1:0] ram_rdata_raw;
  logic [OCC_W-1:0]   occ_inc;
  logic [IDX_W-1:0]   wr_idx_inc, rd_idx_inc;

  assign occ_inc    = occ_r + OCC_W'(1);
  assign wr_idx_inc = (wr_idx_r == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_r + IDX_W'(1);
  assign rd_idx_inc = (rd_idx_r == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_r + IDX_W'(1);

  tbff_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (op.frame),
    .raddr (rd_idx_r),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = frame_t'(ram_rdata_raw);

  // Execute one operation against the frame store and load the result.
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && !pop;
    res_nxt       = res_r;
    op_take       = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (op_valid && (!out_valid_r || pop)) begin
          op_take                = 1'b1;
          res_nxt.reply          = REPLY_NONE;
          res_nxt.frame_valid    = 1'b0;
          res_nxt.frame          = '0;
          res_nxt.fill_level     = FILL_W'(occ_r);
          out_valid_nxt          = 1'b1;
          unique case (op.kind)
            OP_PARTIAL: begin
              res_nxt.reply = REPLY_PARTIAL;
            end
            OP_FRAME: begin
              if (occ_r < OCC_W'(DEPTH)) begin
                ram_we             = 1'b1;
                wr_idx_nxt         = wr_idx_inc;
                occ_nxt            = occ_inc;
                res_nxt.reply      = BYTE_W'(occ_inc);
                res_nxt.fill_level = FILL_W'(occ_inc);
              end
            end
            OP_READ: begin
              if (occ_r != '0) begin
                rd_idx_nxt    = rd_idx_inc;
                occ_nxt       = occ_r - OCC_W'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = BK_READ;
              end
            end
            default: begin
              res_nxt.reply = REPLY_NONE;
            end
          endcase
        end
      end
      BK_READ: begin
        // The store read issued last cycle is now on the RAM output.
        res_nxt.reply       = REPLY_NONE;
        res_nxt.frame_valid = 1'b1;
        res_nxt.frame       = ram_rdata;
        res_nxt.fill_level  = FILL_W'(occ_r);
        out_valid_nxt       = 1'b1;
        state_nxt           = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign empty = !out_valid_r;
  assign res   = res_r;

endmodule

FILE: hw/rtl/three_byte_frame_fifo.sv
// Frame assembler in front of a 16-entry circular frame FIFO.
// Input channel (push/full): each item is either a received byte
// (in_func = 0) or a request to read the oldest stored frame (in_func = 1).
// Every three received bytes form one frame of command, high and low byte.
// Result channel (empty/pop): exactly one result item per input item, in
// order, with the receive reply, the popped frame and the fill level.
// A receive item passes the operation queue and then the result register
// before it shows on the result ports; a read item also passes the
// registered read port of the frame store. While the receiver pops, the
// back part retires one receive item per cycle; a read item also holds it
// in its BK_READ state before it takes the next item. A two-entry operation
// queue lets the input side keep accepting items meanwhile.
// Reset (synchronous, rst_n low) empties the FIFO, restarts the byte
// assembler at the command byte and clears both queues; stored frame data is
// not cleared and no clearing pass is needed.
// When the receiver holds off pop, the result stays on the ports, the
// operation queue fills and full rises after two more items.
`include "three_byte_frame_fifo_defines.svh"

module three_byte_frame_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_reply,
  output logic       out_frame_valid,
  output logic [7:0] out_frame_command,
  output logic [7:0] out_frame_high,
  output logic [7:0] out_frame_low,
  output logic [4:0] out_fill_level
);

  import tbff_pkg::*;

  logic    op_valid;
  op_t     op;
  logic    op_take;
  result_t res;

  // Front part: byte assembly and classification.
  tbff_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .op_valid   (op_valid),
    .op         (op),
    .op_take    (op_take)
  );

  // Back part: FIFO pointers, frame store and result register.
  tbff_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign out_reply         = res.reply;
  assign out_frame_valid   = res.frame_valid;
  assign out_frame_command = res.frame.command;
  assign out_frame_high    = res.frame.high;
  assign out_frame_low     = res.frame.low;
  assign out_fill_level    = res.fill_level;

  // The fill level never goes past the store depth.
  `TBFF_ASSERT_SAME(a_fill_bound, !empty, out_fill_level <= 5'(DEPTH))
  // A popped frame always comes with a zero reply and leaves room behind it.
  `TBFF_ASSERT_SAME(a_pop_reply, !empty && out_frame_valid,
                    out_reply == REPLY_NONE && out_fill_level < 5'(DEPTH))
  // A successful push reports the new fill count as its reply.
  `TBFF_ASSERT_SAME(a_push_count,
                    !empty && out_reply != REPLY_NONE && out_reply != REPLY_PARTIAL,
                    out_reply == 8'(out_fill_level) && !out_frame_valid)
  // A result left unpopped stays available.
  `TBFF_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty)

endmodule
